>>> rtl/core/hashed_timer_wheel_top_macros.svh
`ifndef HASHED_TIMER_WHEEL_TOP_MACROS_SVH
`define HASHED_TIMER_WHEEL_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HTW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/htw_pkg.sv
`default_nettype none

package htw_pkg;

  localparam int ACTION_W  = 3;
  localparam int ID_W      = 6;
  localparam int TIMEOUT_W = 14;
  localparam int SLOTS_W   = 7;
  localparam int ROUNDS_W  = 8;
  localparam int COUNT_W   = 7;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam int DEF_MAX_TIMERS = 64;
  localparam int DEF_MAX_SLOTS  = 64;

  localparam logic [SLOTS_W-1:0]  DEF_WHEEL_SLOTS = 7'd60;
  localparam logic [ROUNDS_W-1:0] DEF_MAX_ROUNDS  = 8'd10;

  // Register index as decoded from paddr[2].
  localparam logic REG_WHEEL_SLOTS = 1'b0;
  localparam logic REG_MAX_ROUNDS  = 1'b1;

  localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 3'd4;

  typedef struct packed {
    logic load;
    logic div_ptr_go;
    logic div_tmo_go;
    logic pmod_load;
    logic add_write;
    logic scan_step;
    logic ptr_adv;
    logic emit_step;
    logic op;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic                reject;
    logic                div_done;
    logic                scan_done;
    logic                emit_done;
    logic                no_fired;
    logic                out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/htw_regs.sv
`default_nettype none

module htw_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [htw_pkg::APB_AW-1:0]       paddr,
  input  wire logic [htw_pkg::APB_DW-1:0]       pwdata,
  output logic      [htw_pkg::APB_DW-1:0]       prdata,
  output logic                                  pready,
  output logic      [htw_pkg::SLOTS_W-1:0]      wheel_slots,
  output logic      [htw_pkg::ROUNDS_W-1:0]     max_rounds
);

  localparam int DW = htw_pkg::APB_DW;

  logic [htw_pkg::SLOTS_W-1:0]  wheel_slots_r;
  logic [htw_pkg::ROUNDS_W-1:0] max_rounds_r;
  logic                         wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_slots_r <= htw_pkg::DEF_WHEEL_SLOTS;
      max_rounds_r  <= htw_pkg::DEF_MAX_ROUNDS;
    end else if (wr_en) begin
      case (paddr[2])
        htw_pkg::REG_WHEEL_SLOTS: wheel_slots_r <= pwdata[htw_pkg::SLOTS_W-1:0];
        htw_pkg::REG_MAX_ROUNDS:  max_rounds_r  <= pwdata[htw_pkg::ROUNDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      htw_pkg::REG_WHEEL_SLOTS: prdata = DW'(wheel_slots_r);
      htw_pkg::REG_MAX_ROUNDS:  prdata = DW'(max_rounds_r);
      default:                  prdata = '0;
    endcase
  end

  assign wheel_slots = wheel_slots_r;
  assign max_rounds  = max_rounds_r;

endmodule

`default_nettype wire

>>> rtl/core/htw_div.sv
`default_nettype none

module htw_div #(
  parameter int DVD_W = htw_pkg::TIMEOUT_W,
  parameter int DVS_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quo,
  output logic      [DVS_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] r_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    shifted = {r_r, q_r[DVD_W-1]};
    diff    = shifted - {1'b0, divisor};
    ge      = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
    end else if (busy_r) begin
      q_r <= {q_r[DVD_W-2:0], ge};
      r_r <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

`default_nettype wire

>>> rtl/core/htw_ctrl.sv
`default_nettype none

module htw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire htw_pkg::sts_t sts,
  output htw_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIVP,
    S_WAITP,
    S_DIVT,
    S_WAITT,
    S_WRITE,
    S_SCAN,
    S_ADV,
    S_EMIT,
    S_OP,
    S_RESP
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_DECODE;
        end
        S_DECODE: begin
          case (sts.act)
            htw_pkg::ACT_ADD:                     state_r <= sts.reject ? S_RESP : S_DIVP;
            htw_pkg::ACT_TICK:                    state_r <= S_DIVP;
            htw_pkg::ACT_REMOVE, htw_pkg::ACT_CLEAR: state_r <= S_OP;
            default:                              state_r <= S_RESP;
          endcase
        end
        S_DIVP:  state_r <= S_WAITP;
        S_WAITP: begin
          if (sts.div_done) state_r <= (sts.act == htw_pkg::ACT_ADD) ? S_DIVT : S_SCAN;
        end
        S_DIVT:  state_r <= S_WAITT;
        S_WAITT: begin
          if (sts.div_done) state_r <= S_WRITE;
        end
        S_WRITE: state_r <= S_RESP;
        S_SCAN: begin
          if (sts.scan_done) state_r <= S_ADV;
        end
        S_ADV:   state_r <= sts.no_fired ? S_RESP : S_EMIT;
        S_EMIT: begin
          if (sts.emit_done) state_r <= S_IDLE;
        end
        S_OP:    state_r <= S_RESP;
        S_RESP: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == S_IDLE) && in_valid;
    cmd.div_ptr_go = state_r == S_DIVP;
    cmd.pmod_load  = (state_r == S_WAITP) && sts.div_done;
    cmd.div_tmo_go = state_r == S_DIVT;
    cmd.add_write  = state_r == S_WRITE;
    cmd.scan_step  = state_r == S_SCAN;
    cmd.ptr_adv    = state_r == S_ADV;
    cmd.emit_step  = state_r == S_EMIT;
    cmd.op         = state_r == S_OP;
    cmd.resp       = state_r == S_RESP;
  end

  assign in_stall = state_r != S_IDLE;

endmodule

`default_nettype wire

>>> rtl/core/htw_dp.sv
`default_nettype none

module htw_dp #(
  parameter int MAX_TIMERS = htw_pkg::DEF_MAX_TIMERS,
  parameter int MAX_SLOTS  = htw_pkg::DEF_MAX_SLOTS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire htw_pkg::cmd_t                    cmd,
  output htw_pkg::sts_t                         sts,
  input  wire logic [htw_pkg::SLOTS_W-1:0]      wheel_slots,
  input  wire logic [htw_pkg::ROUNDS_W-1:0]     max_rounds,
  input  wire logic [htw_pkg::ACTION_W-1:0]     in_action,
  input  wire logic [htw_pkg::ID_W-1:0]         in_timer_id,
  input  wire logic [htw_pkg::TIMEOUT_W-1:0]    in_timeout,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_status,
  output logic                                  out_fired,
  output logic      [htw_pkg::ID_W-1:0]         out_fired_id,
  output logic                                  out_present,
  output logic      [htw_pkg::COUNT_W-1:0]      out_active_count,
  output logic                                  out_last
);

  localparam int IDX_W  = $clog2(MAX_TIMERS);
  localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int SCNT_W = $clog2(MAX_SLOTS + 1);
  localparam int RND_W  = htw_pkg::ROUNDS_W;
  localparam int LIM_W  = SCNT_W + RND_W;
  localparam int ENT_W  = SLOT_W + RND_W;
  localparam int TMO_W  = htw_pkg::TIMEOUT_W;
  localparam int OID_W  = htw_pkg::ID_W;
  localparam int OCNT_W = htw_pkg::COUNT_W;

  // Captured word.
  logic [htw_pkg::ACTION_W-1:0] act_r;
  logic [OID_W-1:0]             id_r;
  logic [TMO_W-1:0]             tmo_r;

  // Wheel state.
  logic [MAX_TIMERS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [SLOT_W-1:0]     ptr_r, ptr_nxt;
  logic [SLOT_W-1:0]     pmod_r;
  logic [LIM_W-1:0]      limit_r;

  // Entry memory: target slot and rounds left per timer.
  logic [ENT_W-1:0] ent_mem_r [MAX_TIMERS];
  logic [ENT_W-1:0] rdata_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [ENT_W-1:0] mem_wd;

  // Scan and emit sequencing.
  logic [IDX_W:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]      pidx_r, pidx_nxt;
  logic                  pv_r, pv_nxt;
  logic [MAX_TIMERS-1:0] hit_r, hit_nxt;
  logic [CNT_W-1:0]      nf_r, nf_nxt;
  logic [CNT_W-1:0]      ecnt_r, ecnt_nxt;
  logic [IDX_W-1:0]      eidx_r, eidx_nxt;

  // Result register.
  logic               ov_r, ov_nxt;
  logic               o_load;
  logic               o_status_nxt, o_status_r;
  logic               o_fired_nxt, o_fired_r;
  logic [OID_W-1:0]   o_id_nxt, o_id_r;
  logic               o_present_nxt, o_present_r;
  logic               o_last_nxt, o_last_r;
  logic [OCNT_W-1:0]  o_cnt_r;

  // Divider.
  logic              div_start;
  logic [TMO_W-1:0]  div_dvd;
  logic              div_done;
  logic [TMO_W-1:0]  div_quo;
  logic [SCNT_W-1:0] div_rem;

  logic [SCNT_W-1:0] slots;
  logic [RND_W-1:0]  rounds_eff;
  logic              id_ok;
  logic [IDX_W-1:0]  id_idx;
  logic              reject;
  logic              out_free;
  logic              emit_done;
  logic              scan_done;
  logic [SLOT_W-1:0] ent_slot;
  logic [RND_W-1:0]  ent_rnd;
  logic              hit;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W:0]   ptr_inc;

  always_comb begin
    if (wheel_slots == '0) begin
      slots = SCNT_W'(1);
    end else if (int'(wheel_slots) > MAX_SLOTS) begin
      slots = SCNT_W'(MAX_SLOTS);
    end else begin
      slots = SCNT_W'(wheel_slots);
    end
    rounds_eff = (max_rounds == '0) ? RND_W'(1) : max_rounds;
  end

  assign id_ok     = int'(id_r) < MAX_TIMERS;
  assign id_idx    = id_r[IDX_W-1:0];
  assign reject    = !id_ok || (tmo_r == '0) || (int'(tmo_r) > int'(limit_r));
  assign out_free  = !ov_r || !out_stall;
  assign emit_done = ecnt_r == nf_r;
  assign scan_done = (idx_r == (IDX_W+1)'(MAX_TIMERS)) && !pv_r;
  assign ent_slot  = rdata_r[ENT_W-1 -: SLOT_W];
  assign ent_rnd   = rdata_r[RND_W-1:0];
  assign hit       = pv_r && valid_r[pidx_r] && (ent_slot == pmod_r);

  assign div_start = cmd.div_ptr_go || cmd.div_tmo_go;
  assign div_dvd   = cmd.div_ptr_go ? TMO_W'(ptr_r) : tmo_r;

  htw_div #(
    .DVD_W (TMO_W),
    .DVS_W (SCNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (slots),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_comb begin
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    pv_nxt        = 1'b0;
    hit_nxt       = hit_r;
    nf_nxt        = nf_r;
    ecnt_nxt      = ecnt_r;
    eidx_nxt      = eidx_r;
    mem_we        = 1'b0;
    mem_wa        = id_idx;
    mem_wd        = '0;
    o_load        = 1'b0;
    o_status_nxt  = 1'b0;
    o_fired_nxt   = 1'b0;
    o_id_nxt      = '0;
    o_present_nxt = 1'b0;
    o_last_nxt    = 1'b1;
    slot_sum      = (SLOT_W+1)'(pmod_r) + (SLOT_W+1)'(div_rem);
    ptr_inc       = (SLOT_W+1)'(pmod_r) + (SLOT_W+1)'(1);

    if (cmd.load) begin
      idx_nxt  = '0;
      hit_nxt  = '0;
      nf_nxt   = '0;
      ecnt_nxt = '0;
      eidx_nxt = '0;
    end

    if (cmd.add_write) begin
      // The offset is below the wheel size, so one subtraction wraps the sum.
      if (int'(slot_sum) >= int'(slots)) begin
        slot_sum = slot_sum - (SLOT_W+1)'(slots);
      end
      mem_we = 1'b1;
      mem_wa = id_idx;
      mem_wd = {slot_sum[SLOT_W-1:0], div_quo[RND_W-1:0]};
      if (!valid_r[id_idx]) begin
        valid_nxt[id_idx] = 1'b1;
        count_nxt         = count_r + CNT_W'(1);
      end
    end

    if (cmd.scan_step) begin
      if (idx_r != (IDX_W+1)'(MAX_TIMERS)) begin
        pidx_nxt = idx_r[IDX_W-1:0];
        pv_nxt   = 1'b1;
        idx_nxt  = idx_r + (IDX_W+1)'(1);
      end
      if (hit) begin
        if (ent_rnd != '0) begin
          mem_we = 1'b1;
          mem_wa = pidx_r;
          mem_wd = {ent_slot, ent_rnd - RND_W'(1)};
        end else begin
          valid_nxt[pidx_r] = 1'b0;
          hit_nxt[pidx_r]   = 1'b1;
          count_nxt         = count_r - CNT_W'(1);
          nf_nxt            = nf_r + CNT_W'(1);
        end
      end
    end

    if (cmd.ptr_adv) begin
      ptr_nxt = (int'(ptr_inc) == int'(slots)) ? '0 : ptr_inc[SLOT_W-1:0];
    end

    // Walk the fired mask in id order, holding on a set bit until the
    // output register can take the word.
    if (cmd.emit_step && !emit_done) begin
      if (hit_r[eidx_r]) begin
        if (out_free) begin
          o_load      = 1'b1;
          o_fired_nxt = 1'b1;
          o_id_nxt    = OID_W'(eidx_r);
          o_last_nxt  = (ecnt_r + CNT_W'(1)) == nf_r;
          ecnt_nxt    = ecnt_r + CNT_W'(1);
          eidx_nxt    = eidx_r + IDX_W'(1);
        end
      end else begin
        eidx_nxt = eidx_r + IDX_W'(1);
      end
    end

    if (cmd.op) begin
      if (act_r == htw_pkg::ACT_REMOVE) begin
        if (id_ok && valid_r[id_idx]) begin
          valid_nxt[id_idx] = 1'b0;
          count_nxt         = count_r - CNT_W'(1);
        end
      end else begin
        valid_nxt = '0;
        count_nxt = '0;
        ptr_nxt   = '0;
      end
    end

    if (cmd.resp && out_free) begin
      o_load        = 1'b1;
      o_status_nxt  = (act_r == htw_pkg::ACT_ADD) && reject;
      o_present_nxt = (act_r == htw_pkg::ACT_QUERY) && id_ok && valid_r[id_idx];
    end

    ov_nxt = o_load ? 1'b1 : (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      ptr_r   <= '0;
      pv_r    <= 1'b0;
      idx_r   <= '0;
      nf_r    <= '0;
      ecnt_r  <= '0;
      eidx_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      pv_r    <= pv_nxt;
      idx_r   <= idx_nxt;
      nf_r    <= nf_nxt;
      ecnt_r  <= ecnt_nxt;
      eidx_r  <= eidx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      id_r  <= in_timer_id;
      tmo_r <= in_timeout;
    end
    if (cmd.pmod_load) begin
      pmod_r <= div_rem[SLOT_W-1:0];
    end
    limit_r <= LIM_W'(slots) * LIM_W'(rounds_eff);
    pidx_r  <= pidx_nxt;
    hit_r   <= hit_nxt;
    if (o_load) begin
      o_status_r  <= o_status_nxt;
      o_fired_r   <= o_fired_nxt;
      o_id_r      <= o_id_nxt;
      o_present_r <= o_present_nxt;
      o_last_r    <= o_last_nxt;
      o_cnt_r     <= OCNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ent_mem_r[mem_wa] <= mem_wd;
    end
    rdata_r <= ent_mem_r[idx_r[IDX_W-1:0]];
  end

  always_comb begin
    sts           = '0;
    sts.act       = act_r;
    sts.reject    = reject;
    sts.div_done  = div_done;
    sts.scan_done = scan_done;
    sts.emit_done = emit_done;
    sts.no_fired  = nf_r == '0;
    sts.out_free  = out_free;
  end

  assign out_valid        = ov_r;
  assign out_status       = o_status_r;
  assign out_fired        = o_fired_r;
  assign out_fired_id     = o_id_r;
  assign out_present      = o_present_r;
  assign out_active_count = o_cnt_r;
  assign out_last         = o_last_r;

endmodule

`default_nettype wire

>>> rtl/core/hashed_timer_wheel_top.sv
`default_nettype none

// Hashed timing wheel for up to MAX_TIMERS timers keyed by id, on a wheel of up to
// MAX_SLOTS slots. Each input word is one action (add, remove, tick, clear, query).
// Each action is answered by one result word, except a tick that expires timers. That
// tick gives one word per expired id in ascending order, with last set on the final
// one. Every word carries the armed count after the whole action. One word is worked
// on at a time. A query, a rejected add or an unknown action goes straight to its
// result, and a remove or a clear first updates the table. An accepted add makes two
// passes of the serial divider (pointer reduction, then slot and round count). A tick
// makes one divider pass, then scans the entry memory at one entry per cycle, then
// walks the fired ids out. An action is held further while a result word waits on
// out_stall. A new word is taken as soon as the previous one is finished, even while
// its last result still waits at the output.

`include "hashed_timer_wheel_top_macros.svh"

module hashed_timer_wheel_top #(
  parameter int MAX_TIMERS = htw_pkg::DEF_MAX_TIMERS,
  parameter int MAX_SLOTS  = htw_pkg::DEF_MAX_SLOTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [htw_pkg::ACTION_W-1:0]      in_action,
  input  wire logic [htw_pkg::ID_W-1:0]          in_timer_id,
  input  wire logic [htw_pkg::TIMEOUT_W-1:0]     in_timeout,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_status,
  output logic                                   out_fired,
  output logic      [htw_pkg::ID_W-1:0]          out_fired_id,
  output logic                                   out_present,
  output logic      [htw_pkg::COUNT_W-1:0]       out_active_count,
  output logic                                   out_last,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [htw_pkg::APB_AW-1:0]        paddr,
  input  wire logic [htw_pkg::APB_DW-1:0]        pwdata,
  output logic      [htw_pkg::APB_DW-1:0]        prdata,
  output logic                                   pready
);

  logic [htw_pkg::SLOTS_W-1:0]  wheel_slots;
  logic [htw_pkg::ROUNDS_W-1:0] max_rounds;
  htw_pkg::cmd_t                cmd;
  htw_pkg::sts_t                sts;

  htw_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .wheel_slots (wheel_slots),
    .max_rounds  (max_rounds)
  );

  htw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  htw_dp #(
    .MAX_TIMERS (MAX_TIMERS),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .wheel_slots      (wheel_slots),
    .max_rounds       (max_rounds),
    .in_action        (in_action),
    .in_timer_id      (in_timer_id),
    .in_timeout       (in_timeout),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_fired        (out_fired),
    .out_fired_id     (out_fired_id),
    .out_present      (out_present),
    .out_active_count (out_active_count),
    .out_last         (out_last)
  );

  // An accepted word keeps the input stalled while it is worked on.
  `HTW_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall, "input not stalled")
  // The divider only finishes in the middle of a word.
  `HTW_ASSERT_IMP(a_div_in_item, sts.div_done, in_stall, "divider done while idle")
  // An expiry report is never also a rejection or a query answer.
  `HTW_ASSERT_IMP(a_fired_clean, out_valid && out_fired, !out_status && !out_present, "fired flags")
  // The armed count never exceeds the timer table.
  `HTW_ASSERT_IMP(a_count_bound, out_valid, int'(out_active_count) <= MAX_TIMERS, "count too big")

endmodule

`default_nettype wire
